// File: hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int BLOCK_BITS   = 512;
    localparam int BLOCK_BYTES  = BLOCK_BITS / 8;
    localparam int BLOCK_WORDS  = BLOCK_BITS / 32;
    localparam int DIGEST_WORDS = 8;
    localparam int ROUNDS       = 64;
    localparam int PAD_LIMIT    = 56;
    localparam int LEN_BITS     = 64;
    localparam int POS_W        = $clog2(BLOCK_BYTES);
    localparam int BLK_CNT_W    = LEN_BITS - $clog2(BLOCK_BITS);
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int WIDX_W       = $clog2(DIGEST_WORDS);
    localparam int JOB_DEPTH    = 2;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    // index 7 holds the first digest word
    typedef logic [DIGEST_WORDS-1:0][31:0] hash_t;

    localparam hash_t HASH_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // one block for the compression unit; index 15 holds the first word
    typedef struct packed {
        logic                         final_blk;
        logic [BLOCK_WORDS-1:0][31:0] block;
    } job_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] t);
        case (t)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

// File: hw/rtl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Packs message bytes into blocks, applies padding and length on finish, and
// hands complete blocks to the job queue.
// ----------------------------------------------------------------------------
module sha_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              action,
    input  logic [7:0]        data_byte,
    output sha_pkg::job_t     job,
    output logic              job_push,
    input  logic              q_full
);

    logic [sha_pkg::BLOCK_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic [sha_pkg::POS_W-1:0]            pos_reg, pos_next;
    logic [sha_pkg::BLK_CNT_W-1:0]        blocks_reg, blocks_next;
    logic                                 tail_pending_reg, tail_pending_next;
    logic [sha_pkg::LEN_BITS-1:0]         tail_len_reg, tail_len_next;

    logic [sha_pkg::BLOCK_BYTES-1:0][7:0] bytes_ins;
    logic [sha_pkg::BLOCK_BYTES-1:0][7:0] bytes_pad;
    logic [sha_pkg::LEN_BITS-1:0]         total;
    logic                                 accept;

    assign full   = q_full || tail_pending_reg;
    assign accept = push && !full;

    // compressed blocks are whole multiples of 512 bits
    assign total = {blocks_reg, pos_reg, 3'b000};

    always_comb
    begin
        // byte at position p sits at index 63 - p, which is ~p
        bytes_ins = bytes_reg;
        bytes_ins[~pos_reg] = data_byte;
        bytes_pad = bytes_reg;
        bytes_pad[~pos_reg] = sha_pkg::PAD_MARK;
    end

    always_comb
    begin
        bytes_next        = bytes_reg;
        pos_next          = pos_reg;
        blocks_next       = blocks_reg;
        tail_pending_next = tail_pending_reg;
        tail_len_next     = tail_len_reg;
        job_push          = 1'b0;
        job.final_blk     = 1'b0;
        job.block         = bytes_ins;

        if (tail_pending_reg)
        begin
            // length-only block after a padded block that had no room
            if (!q_full)
            begin
                job_push          = 1'b1;
                job.final_blk     = 1'b1;
                job.block         = {{(sha_pkg::BLOCK_BITS - sha_pkg::LEN_BITS){1'b0}},
                                     tail_len_reg};
                tail_pending_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (action == sha_pkg::ACT_ABSORB)
            begin
                bytes_next = bytes_ins;
                pos_next   = pos_reg + 1'b1;
                if (pos_reg == sha_pkg::POS_W'(sha_pkg::BLOCK_BYTES - 1))
                begin
                    job_push    = 1'b1;
                    bytes_next  = '0;
                    blocks_next = blocks_reg + 1'b1;
                end
            end
            else
            begin
                job_push    = 1'b1;
                bytes_next  = '0;
                pos_next    = '0;
                blocks_next = '0;
                if (pos_reg < sha_pkg::POS_W'(sha_pkg::PAD_LIMIT))
                begin
                    job.final_blk = 1'b1;
                    job.block     = {bytes_pad[sha_pkg::BLOCK_BYTES-1:sha_pkg::LEN_BITS/8],
                                     total};
                end
                else
                begin
                    job.block         = bytes_pad;
                    tail_pending_next = 1'b1;
                    tail_len_next     = total;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg        <= '0;
            pos_reg          <= '0;
            blocks_reg       <= '0;
            tail_pending_reg <= 1'b0;
        end
        else
        begin
            bytes_reg        <= bytes_next;
            pos_reg          <= pos_next;
            blocks_reg       <= blocks_next;
            tail_pending_reg <= tail_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_len_reg <= tail_len_next;
    end

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == sha_pkg::ACT_FINISH) |=> (pos_reg == '0 && blocks_reg == '0))
        else $error("front state not cleared after finish");

endmodule

// File: hw/rtl/sha_jobq.sv
// ----------------------------------------------------------------------------
// sha_jobq
// Short block queue between the packing front end and the compression unit.
// ----------------------------------------------------------------------------
module sha_jobq #(
    parameter int DEPTH = sha_pkg::JOB_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sha_pkg::job_t wr_job,
    output logic          full,
    output logic          valid,
    output sha_pkg::job_t rd_job,
    input  logic          rd_en
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sha_pkg::job_t    slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign valid  = (count_reg != '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && valid;
    assign rd_job = slots[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            ptr_inc = '0;
        else
            ptr_inc = p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_rd)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots[wr_ptr_reg] <= wr_job;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue count beyond depth");

endmodule

// File: hw/rtl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Round-per-cycle SHA-256 compression with an eight-word digest output buffer.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic          clk,
    input  logic          rst_n,
    input  sha_pkg::job_t job,
    input  logic          job_valid,
    output logic          job_pop,
    output logic          empty,
    input  logic          pop,
    output logic [31:0]   digest_word,
    output logic [2:0]    word_index,
    output logic          last_word
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ROUND  = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    localparam logic [sha_pkg::ROUND_W-1:0] ROUND_LAST = sha_pkg::ROUND_W'(sha_pkg::ROUNDS - 1);
    localparam logic [sha_pkg::WIDX_W-1:0]  WORD_LAST  =
        sha_pkg::WIDX_W'(sha_pkg::DIGEST_WORDS - 1);

    state_t                               state_reg, state_next;
    logic [sha_pkg::ROUND_W-1:0]          round_reg;
    logic                                 final_reg;
    sha_pkg::hash_t                       hash_reg;
    sha_pkg::hash_t                       v_reg, v_next;    // [7] = a ... [0] = h
    logic [sha_pkg::BLOCK_WORDS-1:0][31:0] w_reg;           // [15] = current word
    sha_pkg::hash_t                       dig_reg;
    logic                                 out_valid_reg;
    logic [sha_pkg::WIDX_W-1:0]           out_cnt_reg;

    sha_pkg::hash_t sums;
    logic [31:0]    t1, t2, w_new, ch, maj;
    logic           update_go, out_pop;

    assign job_pop   = (state_reg == ST_IDLE) && job_valid;
    // a final block waits until the previous digest is fully drained
    assign update_go = (state_reg == ST_UPDATE) && (!final_reg || !out_valid_reg);
    assign out_pop   = pop && out_valid_reg;

    assign empty       = !out_valid_reg;
    assign digest_word = dig_reg[sha_pkg::DIGEST_WORDS-1];
    assign word_index  = out_cnt_reg;
    assign last_word   = (out_cnt_reg == WORD_LAST);

    always_comb
    begin
        ch  = (v_reg[3] & v_reg[2]) ^ (~v_reg[3] & v_reg[1]);
        maj = (v_reg[7] & v_reg[6]) ^ (v_reg[7] & v_reg[5]) ^ (v_reg[6] & v_reg[5]);
        t1  = v_reg[0] + sha_pkg::big_sigma1(v_reg[3]) + ch
            + sha_pkg::round_k(round_reg) + w_reg[15];
        t2  = sha_pkg::big_sigma0(v_reg[7]) + maj;
        v_next = {t1 + t2, v_reg[7], v_reg[6], v_reg[5],
                  v_reg[4] + t1, v_reg[3], v_reg[2], v_reg[1]};
        // next schedule word, from the sixteen-word window
        w_new = w_reg[15] + sha_pkg::small_sigma0(w_reg[14]) + w_reg[6]
              + sha_pkg::small_sigma1(w_reg[1]);
        for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++)
            sums[i] = hash_reg[i] + v_reg[i];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == ROUND_LAST)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (update_go)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            hash_reg      <= sha_pkg::HASH_INIT;
            out_valid_reg <= 1'b0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (job_pop)
                round_reg <= '0;
            else if (state_reg == ST_ROUND)
                round_reg <= round_reg + 1'b1;

            if (update_go)
                hash_reg <= final_reg ? sha_pkg::HASH_INIT : sums;

            if (update_go && final_reg)
            begin
                out_valid_reg <= 1'b1;
                out_cnt_reg   <= '0;
            end
            else if (out_pop)
            begin
                out_cnt_reg <= out_cnt_reg + 1'b1;
                if (out_cnt_reg == WORD_LAST)
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            w_reg     <= job.block;
            v_reg     <= hash_reg;
            final_reg <= job.final_blk;
        end
        else if (state_reg == ST_ROUND)
        begin
            w_reg <= {w_reg[sha_pkg::BLOCK_WORDS-2:0], w_new};
            v_reg <= v_next;
        end

        if (update_go && final_reg)
            dig_reg <= sums;
        else if (out_pop)
            dig_reg <= {dig_reg[sha_pkg::DIGEST_WORDS-2:0], 32'h0};
    end

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> (out_cnt_reg == '0))
        else $error("digest word count nonzero while buffer empty");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == ROUND_LAST) |=> (state_reg == ST_UPDATE))
        else $error("round sequence did not end in update");

    a_digest_load: assert property (@(posedge clk) disable iff (!rst_n)
        (update_go && final_reg) |=>
        (out_valid_reg && hash_reg == sha_pkg::HASH_INIT))
        else $error("final block did not load digest and restart hash");

    a_job_start: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (state_reg == ST_ROUND && round_reg == '0))
        else $error("block load did not start at round zero");

endmodule

// File: hw/rtl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream: byte packing front end, block queue and
// round-per-cycle compression unit with digest output buffer.
// ----------------------------------------------------------------------------
// steps: a byte is taken when push is high and full is low; each block holds the
//   compression unit for load, 64 rounds and hash update, one round per cycle
// throughput: one byte per cycle until the block queue fills or a length-only block
//   is pending; digest words leave one per cycle while pop is high
// finish: the first digest word follows the padded block's compression (or the
//   length-only block's); reset: asynchronous, active low, buffers empty
module sha256_byte_stream_hasher #(
    parameter int JOB_DEPTH = sha_pkg::JOB_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha_pkg::job_t front_job;
    sha_pkg::job_t core_job;
    logic          front_push;
    logic          q_full;
    logic          q_valid;
    logic          core_pop;

    sha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .data_byte (data_byte),
        .job       (front_job),
        .job_push  (front_push),
        .q_full    (q_full)
    );

    sha_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_push),
        .wr_job (front_job),
        .full   (q_full),
        .valid  (q_valid),
        .rd_job (core_job),
        .rd_en  (core_pop)
    );

    sha_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (core_job),
        .job_valid   (q_valid),
        .job_pop     (core_pop),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

// File: bench/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches the byte and digest channels of the hasher, keeps its own SHA-256
// state, and compares every digest word against the predicted one.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          mismatch_total,
    output int          digest_words_open
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    localparam logic [0:7][31:0] CHAIN_START = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]  chain [8];
    logic [31:0]  block_words [16];
    int           fill_bytes;
    logic [63:0]  bit_count;
    int           mismatches;
    digest_beat_t expected_words [$];

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void clear_block();
        for (int k = 0; k < 16; k++)
            block_words[k] = 32'h0;
    endfunction

    function automatic void clear_hash_state();
        for (int k = 0; k < 8; k++)
            chain[k] = CHAIN_START[k];
        clear_block();
        fill_bytes = 0;
        bit_count  = 64'h0;
    endfunction

    function automatic void compress_into_chain();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            sched[t] = block_words[t];
        for (int t = 16; t < 64; t++)
        begin
            s0 = ror(sched[t-15], 7) ^ ror(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = ror(sched[t-2], 17) ^ ror(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[t] + sched[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function automatic void place_byte(input int pos, input logic [7:0] val);
        block_words[pos >> 2][31 - 8 * (pos % 4) -: 8] = val;
    endfunction

    function automatic void absorb_byte(input logic [7:0] val);
        place_byte(fill_bytes, val);
        fill_bytes++;
        if (fill_bytes == sha_pkg::BLOCK_BYTES)
        begin
            compress_into_chain();
            bit_count += 64'(sha_pkg::BLOCK_BITS);
            clear_block();
            fill_bytes = 0;
        end
    endfunction

    // pad, append the length, and queue the eight digest words
    function automatic void finish_message();
        int          pos;
        logic [63:0] total;
        pos   = fill_bytes;
        total = bit_count + 64'(pos) * 64'd8;
        place_byte(pos, sha_pkg::PAD_MARK);
        for (int k = pos + 1; k < sha_pkg::BLOCK_BYTES; k++)
            place_byte(k, 8'h00);
        // no room left for the length: it goes in a block of its own
        if (pos >= sha_pkg::PAD_LIMIT)
        begin
            compress_into_chain();
            clear_block();
        end
        block_words[14] = total[63:32];
        block_words[15] = total[31:0];
        compress_into_chain();
        for (int k = 0; k < sha_pkg::DIGEST_WORDS; k++)
            expected_words.push_back('{word: chain[k], index: 3'(k),
                                       last: (k == sha_pkg::DIGEST_WORDS - 1)});
        clear_hash_state();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        digest_beat_t due;
        if (!rst_n)
        begin
            clear_hash_state();
            expected_words.delete();
            mismatches = 0;
            mismatch_total    <= 0;
            digest_words_open <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("digest_word: expected none, actual %h", digest_word);
                    mismatches++;
                end
                else
                begin
                    due = expected_words.pop_front();
                    if (digest_word !== due.word)
                    begin
                        $error("digest_word: expected %h, actual %h", due.word, digest_word);
                        mismatches++;
                    end
                    if (word_index !== due.index)
                    begin
                        $error("word_index: expected %0d, actual %0d", due.index, word_index);
                        mismatches++;
                    end
                    if (last_word !== due.last)
                    begin
                        $error("last_word: expected %0b, actual %0b", due.last, last_word);
                        mismatches++;
                    end
                end
            end
            if (push && !full)
            begin
                if (action == sha_pkg::ACT_FINISH)
                    finish_message();
                else
                    absorb_byte(data_byte);
            end
            mismatch_total    <= mismatches;
            digest_words_open <= expected_words.size();
        end
    end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams and finish beats into the SHA-256 hasher with random
// idling on both channels; a separate checker predicts and compares digests.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_TARGET = 350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 160;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        action;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int mismatch_total;
    int digest_words_open;
    int beats_sent;
    int messages_sent;
    int cycle_count = 0;
    bit feed_calm;
    bit drain_calm = 1'b0;

    sha256_byte_stream_hasher u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    sha256_digest_checker u_digest_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .action            (action),
        .data_byte         (data_byte),
        .empty             (empty),
        .pop               (pop),
        .digest_word       (digest_word),
        .word_index        (word_index),
        .last_word         (last_word),
        .mismatch_total    (mismatch_total),
        .digest_words_open (digest_words_open)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, a few long ones; none at all while calm
    function automatic int idle_cycles(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic int message_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 10);
        else if (r < 90)
            return $urandom_range(11, 30);
        else
            return $urandom_range(54, 66);
    endfunction

    task automatic send_beat(input logic act, input logic [7:0] val);
        int gap;
        gap = idle_cycles(feed_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        action    <= act;
        data_byte <= val;
        do
            @(posedge clk);
        while (full);
        beats_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_beat(sha_pkg::ACT_ABSORB, 8'($urandom));
        send_beat(sha_pkg::ACT_FINISH, 8'($urandom));
        messages_sent++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sha256_byte_stream_hasher regression: fail");
            $finish;
        end
    end

    // digest side: random stalls, with calm stretches of continuous pop
    initial
    begin
        int n;
        pop <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            n = idle_cycles(drain_calm);
            if (n > 0)
            begin
                pop <= 1'b0;
                repeat (n) @(posedge clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                drain_calm = ~drain_calm;
        end
    end

    initial
    begin
        int edge_lengths [4];
        edge_lengths = '{55, 56, 63, 64};
        beats_sent    = 0;
        messages_sent = 0;
        feed_calm     = 1'b0;
        push      <= 1'b0;
        action    <= sha_pkg::ACT_ABSORB;
        data_byte <= 8'h00;
        rst_n     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, then "abc"
        send_beat(sha_pkg::ACT_FINISH, 8'h00);
        send_beat(sha_pkg::ACT_ABSORB, 8'h61);
        send_beat(sha_pkg::ACT_ABSORB, 8'h62);
        send_beat(sha_pkg::ACT_ABSORB, 8'h63);
        send_beat(sha_pkg::ACT_FINISH, 8'hff);
        // byte extremes, then two finish beats in a row
        send_beat(sha_pkg::ACT_ABSORB, 8'h00);
        send_beat(sha_pkg::ACT_ABSORB, 8'hff);
        send_beat(sha_pkg::ACT_FINISH, 8'h5a);
        send_beat(sha_pkg::ACT_FINISH, 8'hff);
        messages_sent = 4;

        // padding edges: length fits, length spills, exact block
        foreach (edge_lengths[k])
        begin
            feed_calm = (k % 2 == 1);
            send_message(edge_lengths[k]);
        end
        while (beats_sent < ITEM_TARGET)
        begin
            feed_calm = ($urandom_range(0, 4) == 0);
            send_message(message_length());
        end
        push <= 1'b0;

        @(posedge clk);
        while (digest_words_open != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d messages in %0d beats: empty, short, and lengths around",
                 messages_sent, beats_sent);
        $display("the pad and block boundaries, with %0d field mismatches", mismatch_total);
        if (mismatch_total == 0)
            $display("sha256_byte_stream_hasher regression: pass");
        else
            $display("sha256_byte_stream_hasher regression: fail");
        $finish;
    end

endmodule

// File: sha256_byte_stream_hasher.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_front.sv
hw/rtl/sha_jobq.sv
hw/rtl/sha_core.sv
hw/rtl/sha256_byte_stream_hasher.sv
bench/sha256_digest_checker.sv
bench/testbench.sv
